>>> src/jitl_pkg.sv
package jitl_pkg;

	typedef struct packed {
		logic signed [31:0] target_position;
		logic signed [31:0] target_velocity;
		logic signed [31:0] measured_position;
		logic signed [31:0] measured_velocity;
		logic [19:0]        period_us;
		logic               measurement_ok;
		logic               hold_target;
	} in_req_t;

	typedef struct packed {
		logic signed [31:0] torque_command;
		logic [1:0]         status;
	} out_rsp_t;

	localparam logic [2:0] REG_STIFFNESS    = 3'd0;
	localparam logic [2:0] REG_DAMPING      = 3'd1;
	localparam logic [2:0] REG_TORQUE_LIMIT = 3'd2;
	localparam logic [2:0] REG_RATE_LIMIT   = 3'd3;
	localparam logic [2:0] REG_FILTER_WGT   = 3'd4;
	localparam logic [2:0] REG_VEL_LIMIT    = 3'd5;

	localparam logic [1:0] STATUS_COMPUTED = 2'd0;
	localparam logic [1:0] STATUS_REPEATED = 2'd1;
	localparam logic [1:0] STATUS_INVALID  = 2'd2;

	localparam logic [31:0] RST_STIFFNESS    = 32'd0;
	localparam logic [31:0] RST_DAMPING      = 32'd0;
	localparam logic [30:0] RST_TORQUE_LIMIT = 31'd65536;
	localparam logic [30:0] RST_RATE_LIMIT   = 31'd65536000;
	localparam logic [16:0] RST_FILTER_WGT   = 17'd64880;
	localparam logic [30:0] RST_VEL_LIMIT    = 31'd65536;

	localparam logic [16:0] ONE_Q16       = 17'd65536;
	localparam logic [19:0] PERIOD_MIN_US = 20'd100;
	localparam logic [19:0] PERIOD_MAX_US = 20'd100000;

	localparam logic [19:0] US_PER_S      = 20'd1000000;
	localparam logic [47:0] US_HALF       = 48'd500000;
	// Floor of 2^51 / 1000000; the quotient estimate from it is low by at most one.
	localparam logic [31:0] RECIP_US      = 32'd2251799813;

endpackage

>>> src/joint_impedance_torque_loop_unit.sv
// Channel  Direction  Handshake             Payload
// in       request    in_valid / in_stall    jitl_pkg::in_req_t
// out      result     out_valid / out_stall  jitl_pkg::out_rsp_t
// cfg      write      cfg_we                 cfg_index, cfg_data
// A computed request passes the velocity filter (ST_F1 to ST_F4), the PD sum and rate product on
// the shared multiplier (ST_P1 to ST_P4), the division of the rate step by one million by a
// reciprocal product and one correction (ST_D0 to ST_Q3), and the two clamps and the output
// load (ST_C1, ST_C2, ST_OUT) on its way to the result register.
// An invalid measurement or a zero period goes from acceptance straight to the output load.
// The input is stalled until the result is loaded, so a new request is not taken while one is
// in progress; a stalled result holds the unit before the load.
// Reset is asynchronous and restores register defaults, zero filter state, a zero last torque and no valid output.
module joint_impedance_torque_loop_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  jitl_pkg::in_req_t   in_req,
	output logic                out_valid,
	input  logic                out_stall,
	output jitl_pkg::out_rsp_t  out_rsp,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [31:0]         cfg_data
);

	typedef enum logic [4:0] {
		ST_IDLE, ST_F1, ST_F2, ST_F3, ST_F4, ST_P1, ST_P2, ST_P3, ST_P4,
		ST_D0, ST_Q1, ST_Q2, ST_Q3, ST_C1, ST_C2, ST_OUT
	} state_t;

	state_t state_q;

	logic [31:0] kp_q, kd_q;
	logic [30:0] tlim_q, rate_q, vlim_q;
	logic [16:0] wgt_q;

	logic signed [31:0] fv_q, last_q, tv_q, mv_q, res_q;
	logic signed [32:0] e1_q, e2_q;
	logic [16:0]        dt_q;
	logic [1:0]         stat_q;
	logic signed [65:0] prod_q;
	logic signed [66:0] acc_q;
	logic signed [50:0] raw_q;
	logic signed [33:0] t_q;
	logic [47:0]        num_q;
	logic [27:0]        quot_q;
	logic               out_valid_q;
	jitl_pkg::out_rsp_t out_rsp_q;

	logic [16:0]        w_sat, w_inv;
	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] prod;
	logic signed [66:0] acc_sum;
	logic signed [31:0] fv_next;
	logic signed [32:0] tv_ext, vl_ext, tv_clamped;
	logic [16:0]        dt_next;
	logic signed [33:0] step_ext, lo_b, hi_b, lim_ext, t_sat;
	logic signed [50:0] lo_ext, hi_ext;
	logic signed [33:0] t_next;
	logic [47:0]        rem_diff;
	logic               rem_ge;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q   <= jitl_pkg::RST_STIFFNESS;
			kd_q   <= jitl_pkg::RST_DAMPING;
			tlim_q <= jitl_pkg::RST_TORQUE_LIMIT;
			rate_q <= jitl_pkg::RST_RATE_LIMIT;
			wgt_q  <= jitl_pkg::RST_FILTER_WGT;
			vlim_q <= jitl_pkg::RST_VEL_LIMIT;
		end else if (cfg_we) begin
			case (cfg_index)
				jitl_pkg::REG_STIFFNESS:    kp_q   <= cfg_data;
				jitl_pkg::REG_DAMPING:      kd_q   <= cfg_data;
				jitl_pkg::REG_TORQUE_LIMIT: tlim_q <= cfg_data[30:0];
				jitl_pkg::REG_RATE_LIMIT:   rate_q <= cfg_data[30:0];
				jitl_pkg::REG_FILTER_WGT:   wgt_q  <= cfg_data[16:0];
				jitl_pkg::REG_VEL_LIMIT:    vlim_q <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		w_sat = (wgt_q > jitl_pkg::ONE_Q16) ? jitl_pkg::ONE_Q16 : wgt_q;
		w_inv = jitl_pkg::ONE_Q16 - w_sat;

		case (state_q)
			ST_F1: begin
				mul_a = $signed({16'd0, w_inv});
				mul_b = $signed({fv_q[31], fv_q});
			end
			ST_F2: begin
				mul_a = $signed({16'd0, w_sat});
				mul_b = $signed({mv_q[31], mv_q});
			end
			ST_P1: begin
				mul_a = $signed({1'b0, kp_q});
				mul_b = e1_q;
			end
			ST_P2: begin
				mul_a = $signed({1'b0, kd_q});
				mul_b = e2_q;
			end
			ST_P4: begin
				mul_a = $signed({2'd0, rate_q});
				mul_b = $signed({16'd0, dt_q});
			end
			ST_Q1: begin
				mul_a = $signed({1'b0, num_q[47:16]});
				mul_b = $signed({1'b0, jitl_pkg::RECIP_US});
			end
			ST_Q2: begin
				mul_a = $signed({5'd0, prod_q[62:35]});
				mul_b = $signed({13'd0, jitl_pkg::US_PER_S});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		prod    = mul_a * mul_b;
		acc_sum = acc_q + $signed({prod_q[65], prod_q});
		fv_next = acc_q[47:16];

		tv_ext = $signed({in_req.target_velocity[31], in_req.target_velocity});
		vl_ext = $signed({2'd0, vlim_q});
		if (tv_ext > vl_ext) begin
			tv_clamped = vl_ext;
		end else if (tv_ext < -vl_ext) begin
			tv_clamped = -vl_ext;
		end else begin
			tv_clamped = tv_ext;
		end

		if (in_req.period_us < jitl_pkg::PERIOD_MIN_US) begin
			dt_next = jitl_pkg::PERIOD_MIN_US[16:0];
		end else if (in_req.period_us > jitl_pkg::PERIOD_MAX_US) begin
			dt_next = jitl_pkg::PERIOD_MAX_US[16:0];
		end else begin
			dt_next = in_req.period_us[16:0];
		end

		rem_diff = num_q - prod_q[47:0];
		rem_ge   = (rem_diff >= {28'd0, jitl_pkg::US_PER_S});

		step_ext = $signed({6'd0, quot_q});
		lo_b     = $signed({{2{last_q[31]}}, last_q}) - step_ext;
		hi_b     = $signed({{2{last_q[31]}}, last_q}) + step_ext;
		lo_ext   = $signed({{17{lo_b[33]}}, lo_b});
		hi_ext   = $signed({{17{hi_b[33]}}, hi_b});
		if (raw_q < lo_ext) begin
			t_next = lo_b;
		end else if (raw_q > hi_ext) begin
			t_next = hi_b;
		end else begin
			t_next = raw_q[33:0];
		end

		lim_ext = $signed({3'd0, tlim_q});
		if (t_q > lim_ext) begin
			t_sat = lim_ext;
		end else if (t_q < -lim_ext) begin
			t_sat = -lim_ext;
		end else begin
			t_sat = t_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fv_q        <= '0;
			last_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_OUT && (!out_valid_q || !out_stall)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						mv_q <= in_req.measured_velocity;
						dt_q <= dt_next;
						if (in_req.hold_target) begin
							e1_q <= '0;
							tv_q <= '0;
						end else begin
							e1_q <= $signed({in_req.target_position[31],
								in_req.target_position})
								- $signed({in_req.measured_position[31],
								in_req.measured_position});
							tv_q <= tv_clamped[31:0];
						end
						if (!in_req.measurement_ok) begin
							res_q   <= '0;
							stat_q  <= jitl_pkg::STATUS_INVALID;
							last_q  <= '0;
							state_q <= ST_OUT;
						end else if (in_req.period_us == '0) begin
							res_q   <= last_q;
							stat_q  <= jitl_pkg::STATUS_REPEATED;
							state_q <= ST_OUT;
						end else begin
							state_q <= ST_F1;
						end
					end
				end
				ST_F1: begin
					prod_q  <= prod;
					acc_q   <= 67'sd32768;
					state_q <= ST_F2;
				end
				ST_F2: begin
					prod_q  <= prod;
					acc_q   <= acc_sum;
					state_q <= ST_F3;
				end
				ST_F3: begin
					acc_q   <= acc_sum;
					state_q <= ST_F4;
				end
				ST_F4: begin
					fv_q    <= fv_next;
					e2_q    <= $signed({tv_q[31], tv_q}) - $signed({fv_next[31], fv_next});
					state_q <= ST_P1;
				end
				ST_P1: begin
					prod_q  <= prod;
					acc_q   <= 67'sd32768;
					state_q <= ST_P2;
				end
				ST_P2: begin
					prod_q  <= prod;
					acc_q   <= acc_sum;
					state_q <= ST_P3;
				end
				ST_P3: begin
					acc_q   <= acc_sum;
					state_q <= ST_P4;
				end
				ST_P4: begin
					raw_q   <= acc_q[66:16];
					prod_q  <= prod;
					state_q <= ST_D0;
				end
				ST_D0: begin
					num_q   <= prod_q[47:0] + jitl_pkg::US_HALF;
					state_q <= ST_Q1;
				end
				ST_Q1: begin
					prod_q  <= prod;
					state_q <= ST_Q2;
				end
				ST_Q2: begin
					quot_q  <= prod_q[62:35];
					prod_q  <= prod;
					state_q <= ST_Q3;
				end
				ST_Q3: begin
					if (rem_ge) begin
						quot_q <= quot_q + 28'd1;
					end
					state_q <= ST_C1;
				end
				ST_C1: begin
					t_q     <= t_next;
					state_q <= ST_C2;
				end
				ST_C2: begin
					res_q   <= t_sat[31:0];
					last_q  <= t_sat[31:0];
					stat_q  <= jitl_pkg::STATUS_COMPUTED;
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!out_valid_q || !out_stall) begin
						out_rsp_q.torque_command <= res_q;
						out_rsp_q.status         <= stat_q;
						state_q                  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_rsp   = out_rsp_q;

endmodule
